>>> sv/tad_pkg.sv
// Shared constants, codes and types of the timer alarm register device.
`default_nettype none
package tad_pkg;

  // Operation codes of one input word
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Register byte offsets
  localparam logic [5:0] OFF_CYC_LO = 6'h00;
  localparam logic [5:0] OFF_CYC_HI = 6'h04;
  localparam logic [5:0] OFF_CD     = 6'h08;
  localparam logic [5:0] OFF_CD_CTL = 6'h0C;
  localparam logic [5:0] OFF_NS_LO  = 6'h10;
  localparam logic [5:0] OFF_NS_HI  = 6'h14;
  localparam logic [5:0] OFF_MS     = 6'h18;
  localparam logic [5:0] OFF_RTC    = 6'h1C;
  localparam logic [5:0] OFF_AL_LO  = 6'h20;
  localparam logic [5:0] OFF_AL_HI  = 6'h24;
  localparam logic [5:0] OFF_HZ     = 6'h28;

  // Configuration register indexes
  localparam logic [1:0] CFG_CPU_HZ = 2'd0;
  localparam logic [1:0] CFG_RTC    = 2'd1;

  localparam logic [31:0] CPU_HZ_RESET = 32'd100000000;
  localparam logic [31:0] NS_PER_SEC   = 32'd1000000000;
  localparam logic [31:0] NS_PER_MS    = 32'd1000000;
  localparam logic [63:0] NS_ROUND     = 64'd999999999;
  localparam logic [31:0] WORD_MAX     = 32'hFFFFFFFF;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage
`default_nettype wire

>>> sv/tad_div.sv
// Bit-serial restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit a cycle.
`default_nettype none
module tad_div import tad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic      [63:0] quo_o,
  output logic      [31:0] rem_o,
  output unit_sts_t        sts_o
);

  logic [63:0] quo_q;
  logic [31:0] rem_q;
  logic [31:0] dsr_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  // One step: shift in the next dividend bit, subtract when it fits
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;
  assign trial = {rem_q, quo_q[63]};
  assign diff  = trial - {1'b0, dsr_q};
  assign fits  = trial >= {1'b0, dsr_q};

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[62:0], fits};
      rem_q <= fits ? diff[31:0] : trial[31:0];
    end
  end

  assign quo_o      = quo_q;
  assign rem_o      = rem_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule
`default_nettype wire

>>> sv/tad_mul.sv
// Shift-add multiplier, 64 by 32 bits, one multiplier bit a cycle.
`default_nettype none
module tad_mul import tad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [95:0] prod_o,
  output unit_sts_t        sts_o
);

  logic [63:0] a_q;
  logic [31:0] b_q;
  logic [95:0] acc_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  // Add the multiplicand into the upper part, then shift right
  logic [64:0] sum;
  assign sum = {1'b0, acc_q[95:32]} + (b_q[0] ? {1'b0, a_q} : 65'd0);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= {1'b0, b_q[31:1]};
      acc_q <= {sum, acc_q[31:1]};
    end
  end

  assign prod_o     = acc_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;

endmodule
`default_nettype wire

>>> sv/timer_alarm_register_device.sv
// Top level of the timer alarm register device: registers, tick logic and sequencer.
//
//   channel | direction | handshake                  | payload
//   in      | in        | in_valid_i / in_ready_o    | op_i, reg_offset_i, write_data_i
//   out     | out       | out_valid_o / out_ready_i  | read_data_o, countdown_irq_o, alarm_irq_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Ticks, plain register reads and writes put their result in the output register in the cycle after acceptance.
// Nanosecond reads take two divides and two multiplies, millisecond reads one more divide,
// seconds reads one divide, alarm arming up to four divides and four multiplies.
// The bit-serial divider and multiplier do this work; one word is in work at a time.
// Reset is asynchronous and clears the device state but loads the clock rate with CPU_HZ_RESET; cfg is always ready.
// A word is accepted only while idle and the output register is free or being drained.
`default_nettype none
module timer_alarm_register_device import tad_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  op_i,
  input  wire logic [5:0]  reg_offset_i,
  input  wire logic [31:0] write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] read_data_o,
  output logic             countdown_irq_o,
  output logic             alarm_irq_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_D1, S_M1, S_M2, S_D2, S_D3, S_D4, S_M4, S_M3, S_D5
  } state_e;

  state_e      state_q;
  logic        go_q;
  logic [31:0] cpu_hz_q;
  logic [31:0] rtc_q;
  logic [63:0] cc_q;
  logic [63:0] cd_deadline_q;
  logic [31:0] cd_period_q;
  logic        periodic_q;
  logic [31:0] cyc_hi_q;
  logic [31:0] ns_hi_q;
  logic [63:0] alarm_inst_q;
  logic [31:0] alarm_lo_q;
  logic [63:0] alarm_cyc_q;
  logic [63:0] acc_q;
  logic [63:0] inst_q;
  logic        ovf_q;
  logic [5:0]  off_q;
  logic        out_valid_q;
  logic [31:0] rdata_q;
  logic        cirq_q;
  logic        airq_q;

  // Serial units
  logic        div_start;
  logic [63:0] div_dvd;
  logic [31:0] div_dsr;
  logic [63:0] div_quo;
  logic [31:0] div_rem;
  unit_sts_t   div_sts;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [31:0] mul_b;
  logic [95:0] mul_prod;
  unit_sts_t   mul_sts;

  logic in_div_state;
  logic in_mul_state;
  assign in_div_state = (state_q == S_D1) || (state_q == S_D2) || (state_q == S_D3) ||
                        (state_q == S_D4) || (state_q == S_D5);
  assign in_mul_state = (state_q == S_M1) || (state_q == S_M2) || (state_q == S_M3) ||
                        (state_q == S_M4);
  assign div_start = go_q && in_div_state;
  assign mul_start = go_q && in_mul_state;

  logic [31:0] hz_eff;
  assign hz_eff = (cpu_hz_q == 32'd0) ? 32'd1 : cpu_hz_q;

  // Divider operands
  always_comb begin
    case (state_q)
      S_D2: begin
        div_dvd = mul_prod[63:0];
        div_dsr = hz_eff;
      end
      S_D3: begin
        div_dvd = acc_q;
        div_dsr = NS_PER_MS;
      end
      S_D4: begin
        div_dvd = inst_q;
        div_dsr = NS_PER_SEC;
      end
      S_D5: begin
        div_dvd = mul_prod[63:0] + NS_ROUND;
        div_dsr = NS_PER_SEC;
      end
      default: begin
        div_dvd = cc_q;
        div_dsr = hz_eff;
      end
    endcase
  end

  // Multiplier operands
  always_comb begin
    case (state_q)
      S_M2: begin
        mul_a = {32'd0, div_rem};
        mul_b = NS_PER_SEC;
      end
      S_M3: begin
        mul_a = {32'd0, div_rem};
        mul_b = hz_eff;
      end
      S_M4: begin
        mul_a = div_quo;
        mul_b = hz_eff;
      end
      default: begin
        mul_a = div_quo;
        mul_b = NS_PER_SEC;
      end
    endcase
  end

  tad_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .quo_o      (div_quo),
    .rem_o      (div_rem),
    .sts_o      (div_sts)
  );

  tad_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (mul_prod),
    .sts_o   (mul_sts)
  );

  // Handshakes
  logic in_acc;
  assign in_ready_o  = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Tick logic
  logic [63:0] cc_inc;
  logic        cd_hit;
  logic        al_hit;
  logic [63:0] cd_next;
  assign cc_inc  = cc_q + 64'd1;
  assign cd_hit  = (cd_deadline_q != 64'd0) && (cc_inc >= cd_deadline_q);
  assign al_hit  = (alarm_inst_q != 64'd0) && (cc_inc >= alarm_cyc_q);
  assign cd_next = (periodic_q && (cd_period_q != 32'd0)) ?
                   cd_deadline_q + {32'd0, cd_period_q} : 64'd0;

  // Countdown read: cycles left, saturated
  logic [63:0] cd_left;
  logic [31:0] cd_read;
  assign cd_left = (cd_deadline_q > cc_q) ? cd_deadline_q - cc_q : 64'd1;
  assign cd_read = (cd_deadline_q == 64'd0) ? 32'd0 :
                   ((cd_left[63:32] != 32'd0) ? WORD_MAX : cd_left[31:0]);

  // Immediate read mux
  logic [31:0] rd_now;
  always_comb begin
    case (reg_offset_i)
      OFF_CYC_LO: rd_now = cc_q[31:0];
      OFF_CYC_HI: rd_now = cyc_hi_q;
      OFF_CD:     rd_now = cd_read;
      OFF_CD_CTL: rd_now = {31'd0, periodic_q};
      OFF_NS_HI:  rd_now = ns_hi_q;
      OFF_AL_LO:  rd_now = alarm_inst_q[31:0];
      OFF_AL_HI:  rd_now = alarm_inst_q[63:32];
      OFF_HZ:     rd_now = cpu_hz_q;
      default:    rd_now = 32'd0;
    endcase
  end

  logic        slow_read;
  logic [63:0] wr_inst;
  logic [63:0] nanos;
  logic [64:0] fc_sum;
  logic        fc_sat;
  assign slow_read = (reg_offset_i == OFF_NS_LO) || (reg_offset_i == OFF_MS) ||
                     (reg_offset_i == OFF_RTC);
  assign wr_inst   = {write_data_i, alarm_lo_q};
  assign nanos     = acc_q + div_quo;
  assign fc_sum    = {1'b0, acc_q} + {1'b0, div_quo};
  assign fc_sat    = ovf_q || fc_sum[64];

  // Sequencer, device state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      go_q          <= 1'b0;
      cpu_hz_q      <= CPU_HZ_RESET;
      rtc_q         <= '0;
      cc_q          <= '0;
      cd_deadline_q <= '0;
      cd_period_q   <= '0;
      periodic_q    <= 1'b0;
      cyc_hi_q      <= '0;
      ns_hi_q       <= '0;
      alarm_inst_q  <= '0;
      alarm_lo_q    <= '0;
      alarm_cyc_q   <= '0;
      acc_q         <= '0;
      inst_q        <= '0;
      ovf_q         <= 1'b0;
      off_q         <= '0;
      out_valid_q   <= 1'b0;
      rdata_q       <= '0;
      cirq_q        <= 1'b0;
      airq_q        <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == CFG_CPU_HZ) begin
          cpu_hz_q <= cfg_data_i;
        end else if (cfg_index_i == CFG_RTC) begin
          rtc_q <= cfg_data_i;
        end
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            out_valid_q <= 1'b1;
            rdata_q     <= 32'd0;
            cirq_q      <= 1'b0;
            airq_q      <= 1'b0;
            off_q       <= reg_offset_i;
            case (op_e'(op_i))
              OP_TICK: begin
                cc_q <= cc_inc;
                if (cd_hit) begin
                  cirq_q        <= 1'b1;
                  cd_deadline_q <= cd_next;
                end
                if (al_hit) begin
                  airq_q       <= 1'b1;
                  alarm_inst_q <= '0;
                end
              end
              OP_READ: begin
                if (slow_read) begin
                  out_valid_q <= 1'b0;
                  state_q     <= S_D1;
                  go_q        <= 1'b1;
                end else begin
                  rdata_q <= rd_now;
                  if (reg_offset_i == OFF_CYC_LO) begin
                    cyc_hi_q <= cc_q[63:32];
                  end
                end
              end
              OP_WRITE: begin
                case (reg_offset_i)
                  OFF_CD: begin
                    cd_period_q   <= write_data_i;
                    cd_deadline_q <= (write_data_i != 32'd0) ?
                                     cc_q + {32'd0, write_data_i} : 64'd0;
                  end
                  OFF_CD_CTL: periodic_q <= write_data_i[0];
                  OFF_AL_LO:  alarm_lo_q <= write_data_i;
                  OFF_AL_HI: begin
                    alarm_lo_q <= '0;
                    inst_q     <= wr_inst;
                    if (wr_inst == 64'd0) begin
                      alarm_inst_q <= '0;
                    end else begin
                      out_valid_q <= 1'b0;
                      state_q     <= S_D1;
                      go_q        <= 1'b1;
                    end
                  end
                  default: ;
                endcase
              end
              default: ;
            endcase
          end
        end
        // cycles / clock
        S_D1: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (div_sts.done) begin
            if (off_q == OFF_RTC) begin
              out_valid_q <= 1'b1;
              rdata_q     <= rtc_q + div_quo[31:0];
              state_q     <= S_IDLE;
            end else begin
              state_q <= S_M1;
              go_q    <= 1'b1;
            end
          end
        end
        // whole seconds in nanoseconds
        S_M1: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (mul_sts.done) begin
            acc_q   <= mul_prod[63:0];
            state_q <= S_M2;
            go_q    <= 1'b1;
          end
        end
        // remainder cycles in nanoseconds
        S_M2: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (mul_sts.done) begin
            state_q <= S_D2;
            go_q    <= 1'b1;
          end
        end
        // fraction, then nanoseconds are ready
        S_D2: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (div_sts.done) begin
            if (off_q == OFF_NS_LO) begin
              ns_hi_q     <= nanos[63:32];
              out_valid_q <= 1'b1;
              rdata_q     <= nanos[31:0];
              state_q     <= S_IDLE;
            end else if (off_q == OFF_MS) begin
              acc_q   <= nanos;
              state_q <= S_D3;
              go_q    <= 1'b1;
            end else if (nanos >= inst_q) begin
              alarm_inst_q <= '0;
              out_valid_q  <= 1'b1;
              airq_q       <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              state_q <= S_D4;
              go_q    <= 1'b1;
            end
          end
        end
        // milliseconds
        S_D3: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (div_sts.done) begin
            out_valid_q <= 1'b1;
            rdata_q     <= div_quo[31:0];
            state_q     <= S_IDLE;
          end
        end
        // instant split into seconds and nanoseconds
        S_D4: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (div_sts.done) begin
            state_q <= S_M4;
            go_q    <= 1'b1;
          end
        end
        // whole seconds in cycles, with overflow
        S_M4: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (mul_sts.done) begin
            acc_q   <= mul_prod[63:0];
            ovf_q   <= (mul_prod[95:64] != 32'd0);
            state_q <= S_M3;
            go_q    <= 1'b1;
          end
        end
        // nanoseconds times clock
        S_M3: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (mul_sts.done) begin
            state_q <= S_D5;
            go_q    <= 1'b1;
          end
        end
        // rounded-up fraction cycles, then arm
        S_D5: begin
          if (go_q) begin
            go_q <= 1'b0;
          end else if (div_sts.done) begin
            alarm_inst_q <= inst_q;
            alarm_cyc_q  <= fc_sat ? {64{1'b1}} : fc_sum[63:0];
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = rdata_q;
  assign countdown_irq_o = cirq_q;
  assign alarm_irq_o     = airq_q;

  // Checks
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(div_sts.busy && mul_sts.busy))
    else $error("divider and multiplier busy together");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("input ready while a word is in work");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_sts.done |-> in_div_state)
    else $error("divider finished outside a divide step");

  a_mul_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> in_mul_state)
    else $error("multiplier finished outside a multiply step");

  a_alarm_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (op_i == OP_TICK) && al_hit) |=> (alarm_inst_q == 64'd0))
    else $error("alarm still armed after firing");

endmodule
`default_nettype wire
